@@ src/sespc_pkg.sv @@
// Shared types, constants and constant tables of the shelf EQ and peak compressor.
package sespc_pkg;

  localparam int MUL_W    = 33;
  localparam int ACC_W    = 68;
  localparam int LOG_FRAC = 16;
  localparam int COEF_W   = 28;
  localparam int CFG_W    = 28;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_B0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ATK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_THR = 3'd7;

  typedef struct packed {
    logic start;
    logic clr;
    logic neg;
  } mac_req_t;

  // Makeup gain in Q3.24 for 0..12 dB
  localparam logic [26:0] MAKEUP_TBL [13] = '{
    27'd16777216, 27'd18824346, 27'd21121264, 27'd23698447, 27'd26590095,
    27'd29834578, 27'd33474947, 27'd37559508, 27'd42142461, 27'd47284619,
    27'd53054215, 27'd59527809, 27'd66791300
  };

  // Factor 2^-(2^-k) in Q1.30, by repeated truncated square roots from 0.5
  function automatic logic [29:0] exp_factor(input int k);
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bm;
    c = 64'd1 << 29;
    for (int j = 0; j < k; j++) begin
      v  = c << 30;
      r  = 64'd0;
      bm = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (v >= r + bm) begin
          v = v - (r + bm);
          r = (r >> 1) + bm;
        end else begin
          r = r >> 1;
        end
        bm = bm >> 2;
      end
      c = r;
    end
    return c[29:0];
  endfunction

  localparam logic [29:0] EXP_C [16] = '{
    exp_factor(1),  exp_factor(2),  exp_factor(3),  exp_factor(4),
    exp_factor(5),  exp_factor(6),  exp_factor(7),  exp_factor(8),
    exp_factor(9),  exp_factor(10), exp_factor(11), exp_factor(12),
    exp_factor(13), exp_factor(14), exp_factor(15), exp_factor(16)
  };

endpackage

@@ src/sespc_mac.sv @@
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle.
module sespc_mac import sespc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_req_t                req_i,
  input  logic signed [MUL_W-1:0] a_i,
  input  logic signed [MUL_W-1:0] b_i,
  output logic signed [ACC_W-1:0] acc_o,
  output logic                    done_o
);

  localparam int CNT_W = $clog2(MUL_W);

  logic signed [ACC_W-1:0] acc_q, mcand_q;
  logic [MUL_W-1:0]        mplier_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    busy_q, neg_q, done_q;
  logic                    last, sub;

  assign last = (cnt_q == CNT_W'(MUL_W - 1));
  // top multiplier bit carries negative weight
  assign sub  = last ^ neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        neg_q  <= req_i.neg;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mcand_q  <= ACC_W'(a_i);
      mplier_q <= b_i;
      if (req_i.clr) acc_q <= '0;
    end else if (busy_q) begin
      if (mplier_q[0]) acc_q <= sub ? acc_q - mcand_q : acc_q + mcand_q;
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

@@ src/shelf_eq_stereo_peak_compressor_unit.sv @@
// Stereo low-shelf biquad with linked peak compressor, top level and sequencer.
// Work per stereo pair: 14 to 47 products on the one bit-serial MAC, plus the serial
//   normalizer, divider and gain shifter.
// Throughput: one pair at a time; the next pair is taken once the result is in the
//   output register. Reset clears the filter history, envelope and output valid, and loads the configuration defaults.
module shelf_eq_stereo_peak_compressor_unit import sespc_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int RATIO        = 4,
  parameter int MAKEUP_DB    = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // left_in, right_in
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // left_out, right_out
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int TDATA_W = ((2*SAMPLE_WIDTH+7)/8)*8;
  localparam int SW      = SAMPLE_WIDTH;
  localparam int RATIO_C = (RATIO < 1) ? 1 : RATIO;
  localparam int MK_C    = (MAKEUP_DB < 0) ? 0 : ((MAKEUP_DB > 12) ? 12 : MAKEUP_DB);
  localparam int OVER_W  = 24;
  localparam int NUM_W   = OVER_W + $clog2(RATIO_C);
  localparam int DCNT_W  = $clog2(NUM_W);
  localparam int REM_W   = $clog2(RATIO_C) + 2;
  localparam logic [26:0] MAKEUP = MAKEUP_TBL[MK_C];
  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(64'd8388608);
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'd1 << (SW-1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;
  localparam logic signed [7:0] EXP_OFF = 8'(SW-1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BQ    = 4'd1;
  localparam logic [3:0] S_ENV1  = 4'd2;
  localparam logic [3:0] S_ENV2  = 4'd3;
  localparam logic [3:0] S_NORM  = 4'd4;
  localparam logic [3:0] S_LOG   = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_EXP   = 4'd8;
  localparam logic [3:0] S_SHIFT = 4'd9;
  localparam logic [3:0] S_GAIN  = 4'd10;
  localparam logic [3:0] S_OUTL  = 4'd11;
  localparam logic [3:0] S_OUTR  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  function automatic logic signed [SW-1:0] sat_rnd(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    t = (a + RND) >>> 24;
    if (t > SMAX) t = SMAX;
    else if (t < SMIN) t = SMIN;
    return t[SW-1:0];
  endfunction

  // configuration
  logic signed [COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [23:0]              atk_q, rel_q;
  logic signed [15:0]       thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q  <= COEF_W'(28'd16777216);
      b1_q  <= '0;
      b2_q  <= '0;
      a1_q  <= '0;
      a2_q  <= '0;
      atk_q <= '0;
      rel_q <= '0;
      thr_q <= -16'sd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_B0:  b0_q  <= cfg_data_i;
        REG_B1:  b1_q  <= cfg_data_i;
        REG_B2:  b2_q  <= cfg_data_i;
        REG_A1:  a1_q  <= cfg_data_i;
        REG_A2:  a2_q  <= cfg_data_i;
        REG_ATK: atk_q <= cfg_data_i[23:0];
        REG_REL: rel_q <= cfg_data_i[23:0];
        REG_THR: thr_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // datapath state
  logic [3:0]               state_q;
  logic                     issued_q, ch_q;
  logic [2:0]               term_q;
  logic signed [31:0]       xl_q, xr_q;
  logic signed [31:0]       hl_q [4];
  logic signed [31:0]       hr_q [4];
  logic signed [SW-1:0]     yl_q, yr_q, ol_q, or_q;
  logic [31:0]              env_q, nv_q;
  logic [4:0]               p_q;
  logic [30:0]              m_q, g_q;
  logic [15:0]              frac_q;
  logic [4:0]               k_q, sh_q;
  logic [NUM_W-1:0]         num_q;
  logic [REM_W-1:0]         rem_q;
  logic [DCNT_W-1:0]        dcnt_q;
  logic [26:0]              gain_q;
  logic                     m_valid_q;
  logic [TDATA_W-1:0]       m_data_q;

  mac_req_t                 mac_req;
  logic signed [MUL_W-1:0]  mac_a, mac_b;
  logic signed [ACC_W-1:0]  mac_acc;
  logic                     mac_done;

  sespc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (mac_acc),
    .done_o (mac_done)
  );

  logic signed [31:0]       yl32, yr32, bq_x;
  logic [31:0]              ayl, ayr, peak;
  logic [23:0]              csel;
  logic signed [ACC_W-1:0]  env_sum;
  logic [31:0]              env_new, sq;
  logic signed [7:0]        pint;
  logic signed [23:0]       lv, th;
  logic [OVER_W-1:0]        over;
  logic [REM_W-1:0]         rem_sh;
  logic                     rem_ge, fbit;
  logic [NUM_W-17:0]        ip;
  logic signed [SW-1:0]     ybq;

  always_comb begin
    yl32    = 32'(yl_q);
    yr32    = 32'(yr_q);
    ayl     = yl_q[SW-1] ? 32'(-yl32) : 32'(yl32);
    ayr     = yr_q[SW-1] ? 32'(-yr32) : 32'(yr32);
    peak    = (ayl > ayr) ? ayl : ayr;
    csel    = (peak > env_q) ? atk_q : rel_q;
    env_sum = mac_acc + RND;
    env_new = env_sum[55:24];
    sq      = mac_acc[61:30];
    pint    = $signed({3'b000, p_q}) - EXP_OFF;
    lv      = {pint, frac_q};
    th      = {{2{thr_q[15]}}, thr_q, 6'b000000};
    over    = OVER_W'(lv - th);
    rem_sh  = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
    rem_ge  = (rem_sh >= REM_W'(RATIO_C));
    fbit    = num_q[4'(5'd16 - k_q)];
    ip      = num_q[NUM_W-1:16];
    ybq     = sat_rnd(mac_acc);
    bq_x    = ch_q ? xr_q : xl_q;
  end

  // operand selection for the shared MAC
  always_comb begin
    mac_req   = '0;
    mac_a     = '0;
    mac_b     = '0;
    mac_req.start = !issued_q;
    case (state_q)
      S_BQ: begin
        mac_req.clr = (term_q == 3'd0);
        mac_req.neg = (term_q >= 3'd3);
        case (term_q)
          3'd0: begin mac_a = MUL_W'(b0_q); mac_b = MUL_W'(bq_x); end
          3'd1: begin
            mac_a = MUL_W'(b1_q);
            mac_b = MUL_W'(ch_q ? hr_q[0] : hl_q[0]);
          end
          3'd2: begin
            mac_a = MUL_W'(b2_q);
            mac_b = MUL_W'(ch_q ? hr_q[1] : hl_q[1]);
          end
          3'd3: begin
            mac_a = MUL_W'(a1_q);
            mac_b = MUL_W'(ch_q ? hr_q[2] : hl_q[2]);
          end
          default: begin
            mac_a = MUL_W'(a2_q);
            mac_b = MUL_W'(ch_q ? hr_q[3] : hl_q[3]);
          end
        endcase
      end
      S_ENV1: begin
        mac_req.clr = 1'b1;
        mac_a = MUL_W'(csel);
        mac_b = MUL_W'(env_q);
      end
      S_ENV2: begin
        mac_a = MUL_W'(25'h1000000 - {1'b0, csel});
        mac_b = MUL_W'(peak);
      end
      S_LOG: begin
        mac_req.clr = 1'b1;
        mac_a = MUL_W'(m_q);
        mac_b = MUL_W'(m_q);
      end
      S_EXP: begin
        mac_req.clr   = 1'b1;
        mac_req.start = !issued_q && fbit && (k_q != 5'd17);
        mac_a = MUL_W'(g_q);
        mac_b = MUL_W'(EXP_C[4'(k_q - 5'd1)]);
      end
      S_GAIN: begin
        mac_req.clr = 1'b1;
        mac_a = MUL_W'(MAKEUP);
        mac_b = MUL_W'(g_q);
      end
      S_OUTL: begin
        mac_req.clr = 1'b1;
        mac_a = MUL_W'(yl_q);
        mac_b = MUL_W'(gain_q);
      end
      S_OUTR: begin
        mac_req.clr = 1'b1;
        mac_a = MUL_W'(yr_q);
        mac_b = MUL_W'(gain_q);
      end
      default: mac_req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      issued_q  <= 1'b0;
      ch_q      <= 1'b0;
      term_q    <= '0;
      m_valid_q <= 1'b0;
      env_q     <= '0;
      for (int i = 0; i < 4; i++) begin
        hl_q[i] <= '0;
        hr_q[i] <= '0;
      end
    end else begin
      if (m_valid_q && m_axis_tready && (state_q != S_DONE)) m_valid_q <= 1'b0;
      if (mac_req.start) issued_q <= 1'b1;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            xl_q    <= 32'($signed(s_axis_tdata[SW-1:0]));
            xr_q    <= 32'($signed(s_axis_tdata[2*SW-1:SW]));
            ch_q    <= 1'b0;
            term_q  <= '0;
            state_q <= S_BQ;
          end
        end
        S_BQ: begin
          if (mac_done) begin
            issued_q <= 1'b0;
            if (term_q != 3'd4) begin
              term_q <= term_q + 3'd1;
            end else if (!ch_q) begin
              yl_q    <= ybq;
              hl_q[1] <= hl_q[0];
              hl_q[0] <= xl_q;
              hl_q[3] <= hl_q[2];
              hl_q[2] <= 32'(ybq);
              ch_q    <= 1'b1;
              term_q  <= '0;
            end else begin
              yr_q    <= ybq;
              hr_q[1] <= hr_q[0];
              hr_q[0] <= xr_q;
              hr_q[3] <= hr_q[2];
              hr_q[2] <= 32'(ybq);
              state_q <= S_ENV1;
            end
          end
        end
        S_ENV1: begin
          if (mac_done) begin
            issued_q <= 1'b0;
            state_q  <= S_ENV2;
          end
        end
        S_ENV2: begin
          if (mac_done) begin
            issued_q <= 1'b0;
            env_q    <= env_new;
            nv_q     <= env_new;
            p_q      <= 5'd31;
            if (env_new == 32'd0) begin
              gain_q  <= MAKEUP;
              state_q <= S_OUTL;
            end else begin
              state_q <= S_NORM;
            end
          end
        end
        S_NORM: begin
          // shift up until the leading one reaches the top bit
          if (nv_q[31]) begin
            m_q     <= nv_q[31:1];
            frac_q  <= '0;
            k_q     <= '0;
            state_q <= S_LOG;
          end else begin
            nv_q <= nv_q << 1;
            p_q  <= p_q - 5'd1;
          end
        end
        S_LOG: begin
          if (mac_done) begin
            issued_q <= 1'b0;
            frac_q   <= {frac_q[14:0], sq[31]};
            m_q      <= sq[31] ? sq[31:1] : sq[30:0];
            k_q      <= k_q + 5'd1;
            if (k_q == 5'd15) state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (lv > th) begin
            num_q   <= NUM_W'(over) * NUM_W'(RATIO_C - 1);
            rem_q   <= '0;
            dcnt_q  <= '0;
            state_q <= S_DIV;
          end else begin
            gain_q  <= MAKEUP;
            state_q <= S_OUTL;
          end
        end
        S_DIV: begin
          // restoring division by the ratio, one quotient bit per cycle
          rem_q  <= rem_ge ? rem_sh - REM_W'(RATIO_C) : rem_sh;
          num_q  <= {num_q[NUM_W-2:0], rem_ge};
          dcnt_q <= dcnt_q + DCNT_W'(1);
          if (dcnt_q == DCNT_W'(NUM_W - 1)) begin
            k_q     <= 5'd1;
            g_q     <= 31'h40000000;
            state_q <= S_EXP;
          end
        end
        S_EXP: begin
          if (k_q == 5'd17) begin
            issued_q <= 1'b0;
            if (ip >= (NUM_W-16)'(31)) begin
              g_q  <= '0;
              sh_q <= '0;
            end else begin
              sh_q <= ip[4:0];
            end
            state_q <= S_SHIFT;
          end else if (!fbit) begin
            k_q <= k_q + 5'd1;
          end else if (mac_done) begin
            issued_q <= 1'b0;
            g_q      <= mac_acc[60:30];
            k_q      <= k_q + 5'd1;
          end
        end
        S_SHIFT: begin
          if (sh_q == 5'd0) begin
            state_q <= S_GAIN;
          end else begin
            g_q  <= g_q >> 1;
            sh_q <= sh_q - 5'd1;
          end
        end
        S_GAIN: begin
          if (mac_done) begin
            issued_q <= 1'b0;
            gain_q   <= mac_acc[56:30];
            state_q  <= S_OUTL;
          end
        end
        S_OUTL: begin
          if (mac_done) begin
            issued_q <= 1'b0;
            ol_q     <= ybq;
            state_q  <= S_OUTR;
          end
        end
        S_OUTR: begin
          if (mac_done) begin
            issued_q <= 1'b0;
            or_q     <= ybq;
            state_q  <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= TDATA_W'({or_q, ol_q});
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

@@ src/sespc_chk.sv @@
// Port-level checker for the shelf EQ and peak compressor, bound to the top level.
module sespc_chk #(
  parameter int TDATA_W = 48
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [TDATA_W-1:0]   m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction dropped or changed while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input taken while a transaction is in work");

  a_ready_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result posted while still busy");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !$rose(m_axis_tvalid))
    else $error("result appeared one cycle after input");

endmodule

bind shelf_eq_stereo_peak_compressor_unit sespc_chk #(.TDATA_W(TDATA_W)) u_sespc_chk (.*);
